### hdl/can_frame_signal_decoder_assert.svh
// Assertion helpers shared by the decoder modules.
// Both sample on clock and are switched off while reset is high.
`ifndef CAN_FRAME_SIGNAL_DECODER_ASSERT_SVH
`define CAN_FRAME_SIGNAL_DECODER_ASSERT_SVH

// Same-cycle implication.
`define CFSD_ASSERT_IMP(name, a, c) \
   name: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define CFSD_ASSERT_NXT(name, a, c) \
   name: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("next-cycle check failed");

`endif

### hdl/cfsd_pkg.sv
package cfsd_pkg;

   localparam int TIME_BITS = 48;

   localparam int QueueDepth   = 2;
   localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   // Identifier masks and bases, cut to the 29 identifier bits.
   localparam logic [28:0] IdMaskJoy    = 29'h0FFF_0FFF;
   localparam logic [28:0] IdBaseJoy    = 29'h0200_0000;
   localparam logic [28:0] IdExactJoy   = 29'h0200_0300;
   localparam logic [28:0] IdMaskGroup  = 29'h1FFF_F0FF;
   localparam logic [28:0] IdBaseBatt   = 29'h1C0C_0000;
   localparam logic [28:0] IdBaseMotor  = 29'h1430_0000;
   localparam logic [28:0] IdBaseDist   = 29'h1C30_0004;
   localparam logic [28:0] IdBaseSpeed  = 29'h0A04_0000;
   localparam logic [28:0] IdBaseBeat   = 29'h0C14_0000;
   localparam logic [28:0] IdBaseLamp   = 29'h0C00_0E00;
   localparam logic [28:0] IdMaskEnable = 29'h1FFF_F000;
   localparam logic [28:0] IdBaseEnable = 29'h0C18_0000;

   typedef enum logic [2:0] {
      KIND_JOYSTICK,
      KIND_BATTERY,
      KIND_MOTOR_CURRENT,
      KIND_DISTANCE,
      KIND_MAX_SPEED,
      KIND_HEARTBEAT,
      KIND_LAMP,
      KIND_ENABLE
   } signal_kind_type;

   // One classified frame waiting for the back end.
   typedef struct packed {
      signal_kind_type        kind;
      logic                   two_samples;
      logic [32:0]            value0;
      logic [32:0]            value1;
      logic [55:0]            source;
      logic [TIME_BITS-1:0]   time_ms;
   } entry_type;

   // Handshake between a queue and its neighbours.
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

### hdl/can_frame_signal_decoder.sv
// CAN frame signal decoder.
// Request side: present a frame on the req_ ports with req_push high; it is
// taken at an edge where req_full is low. Remote, error, standard-identifier
// and source-key-zero frames, and frames matching no identifier entry, are
// taken and leave nothing behind.
// Response side: while rsp_empty is low the oldest sample sits on the rsp_
// ports; rsp_pop high at an edge removes it. A frame gives one or two samples,
// the last one flagged by rsp_last_of_frame, each carrying the running
// earliest/latest timestamp after that frame.
// Path: a matching frame is written into the frame queue, then moved into
// the output register once that is free. Throughput: one request per cycle
// while req_full is low; the output register issues one sample per cycle
// while rsp_pop drains it. A two-entry frame queue sits between classifier
// and emitter. Stall: with rsp_pop low the output register holds, the queue
// fills and req_full rises after two more matching frames.
// Reset clears the queue, the output register and the timestamp range.
module can_frame_signal_decoder
   import cfsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [55:0]           req_source_key,
   input  logic [28:0]           req_can_id,
   input  logic                  req_is_extended,
   input  logic                  req_is_remote,
   input  logic                  req_error_flag,
   input  logic [3:0]            req_data_length,
   input  logic [63:0]           req_payload,
   input  logic [TIME_BITS-1:0]  req_time_ms,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [2:0]            rsp_signal_kind,
   output logic                  rsp_channel,
   output logic signed [32:0]    rsp_sample_value,
   output logic [55:0]           rsp_sample_source,
   output logic [TIME_BITS-1:0]  rsp_sample_time_ms,
   output logic                  rsp_last_of_frame,
   output logic [TIME_BITS-1:0]  rsp_earliest_time_ms,
   output logic [TIME_BITS-1:0]  rsp_latest_time_ms
);

   queue_ctrl_type q_ctrl;
   queue_stat_type q_stat;
   entry_type      q_wr_entry;
   entry_type      q_rd_entry;
   logic           q_push;
   logic           q_pop;

   assign q_ctrl.push = q_push;
   assign q_ctrl.pop  = q_pop;

   cfsd_front u_front (
      .req_push        (req_push),
      .req_source_key  (req_source_key),
      .req_can_id      (req_can_id),
      .req_is_extended (req_is_extended),
      .req_is_remote   (req_is_remote),
      .req_error_flag  (req_error_flag),
      .req_data_length (req_data_length),
      .req_payload     (req_payload),
      .req_time_ms     (req_time_ms),
      .q_full          (q_stat.full),
      .req_full        (req_full),
      .q_push          (q_push),
      .q_entry         (q_wr_entry)
   );

   cfsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .wr_entry (q_wr_entry),
      .stat     (q_stat),
      .rd_entry (q_rd_entry)
   );

   cfsd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_stat               (q_stat),
      .q_entry              (q_rd_entry),
      .q_pop                (q_pop),
      .rsp_pop              (rsp_pop),
      .rsp_empty            (rsp_empty),
      .rsp_signal_kind      (rsp_signal_kind),
      .rsp_channel          (rsp_channel),
      .rsp_sample_value     (rsp_sample_value),
      .rsp_sample_source    (rsp_sample_source),
      .rsp_sample_time_ms   (rsp_sample_time_ms),
      .rsp_last_of_frame    (rsp_last_of_frame),
      .rsp_earliest_time_ms (rsp_earliest_time_ms),
      .rsp_latest_time_ms   (rsp_latest_time_ms)
   );

endmodule

### hdl/cfsd_front.sv
module cfsd_front
   import cfsd_pkg::*;
(
   input  logic                  req_push,
   input  logic [55:0]           req_source_key,
   input  logic [28:0]           req_can_id,
   input  logic                  req_is_extended,
   input  logic                  req_is_remote,
   input  logic                  req_error_flag,
   input  logic [3:0]            req_data_length,
   input  logic [63:0]           req_payload,
   input  logic [TIME_BITS-1:0]  req_time_ms,
   input  logic                  q_full,
   output logic                  req_full,
   output logic                  q_push,
   output entry_type             q_entry
);

   logic        keep;
   logic        hit;
   logic        len_ge1;
   logic        len_ge2;
   logic        len_ge8;
   logic [28:0] id_grp;
   logic [7:0]  b0, b1;

   always_comb begin
      b0      = req_payload[7:0];
      b1      = req_payload[15:8];
      len_ge1 = (req_data_length != 4'd0);
      len_ge2 = (req_data_length >= 4'd2);
      len_ge8 = (req_data_length >= 4'd8);
      id_grp  = req_can_id & IdMaskGroup;
      keep    = (req_source_key != 56'd0) && !req_is_remote && !req_error_flag
                && req_is_extended;

      hit                 = 1'b1;
      q_entry.kind        = KIND_JOYSTICK;
      q_entry.two_samples = 1'b0;
      q_entry.value0      = {25'd0, b0};
      q_entry.value1      = {25'd0, b1};
      q_entry.source      = req_source_key;
      q_entry.time_ms     = req_time_ms;

      // first matching entry wins; a short payload falls through
      priority if ((((req_can_id & IdMaskJoy) == IdBaseJoy) || (req_can_id == IdExactJoy))
                   && len_ge2) begin
         q_entry.kind        = KIND_JOYSTICK;
         q_entry.two_samples = 1'b1;
         q_entry.value0      = {{25{b0[7]}}, b0};
         q_entry.value1      = {{25{b1[7]}}, b1};
      end else if (id_grp == IdBaseBatt && len_ge1) begin
         q_entry.kind = KIND_BATTERY;
      end else if (id_grp == IdBaseMotor && len_ge2) begin
         q_entry.kind   = KIND_MOTOR_CURRENT;
         q_entry.value0 = {17'd0, b1, b0};
      end else if (id_grp == IdBaseDist && len_ge8) begin
         q_entry.kind        = KIND_DISTANCE;
         q_entry.two_samples = 1'b1;
         q_entry.value0      = {1'b0, req_payload[31:0]};
         q_entry.value1      = {1'b0, req_payload[63:32]};
      end else if (id_grp == IdBaseSpeed && len_ge1) begin
         q_entry.kind = KIND_MAX_SPEED;
      end else if (id_grp == IdBaseBeat && len_ge1) begin
         q_entry.kind = KIND_HEARTBEAT;
      end else if (id_grp == IdBaseLamp && len_ge2) begin
         q_entry.kind        = KIND_LAMP;
         q_entry.two_samples = 1'b1;
      end else if ((req_can_id & IdMaskEnable) == IdBaseEnable && len_ge1) begin
         q_entry.kind = KIND_ENABLE;
      end else begin
         hit = 1'b0;
      end

      req_full = q_full;
      // drop the request unless it passes the filter and matches
      q_push   = req_push && !q_full && keep && hit;
   end

endmodule

### hdl/cfsd_queue.sv
`include "can_frame_signal_decoder_assert.svh"

module cfsd_queue
   import cfsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_ctrl_type ctrl,
   input  entry_type      wr_entry,
   output queue_stat_type stat,
   output entry_type      rd_entry
);

   entry_type                mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0]  count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   always_comb begin
      stat.full  = (count_ff == QueueCntBits'(QueueDepth));
      stat.empty = (count_ff == '0);
      do_push    = ctrl.push && !stat.full;
      do_pop     = ctrl.pop && !stat.empty;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      rd_entry = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   `CFSD_ASSERT_IMP(a_q_bound, 1'b1, count_ff <= QueueCntBits'(QueueDepth))
   `CFSD_ASSERT_NXT(a_q_drain, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1)

endmodule

### hdl/cfsd_back.sv
`include "can_frame_signal_decoder_assert.svh"

module cfsd_back
   import cfsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  queue_stat_type        q_stat,
   input  entry_type             q_entry,
   output logic                  q_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [2:0]            rsp_signal_kind,
   output logic                  rsp_channel,
   output logic signed [32:0]    rsp_sample_value,
   output logic [55:0]           rsp_sample_source,
   output logic [TIME_BITS-1:0]  rsp_sample_time_ms,
   output logic                  rsp_last_of_frame,
   output logic [TIME_BITS-1:0]  rsp_earliest_time_ms,
   output logic [TIME_BITS-1:0]  rsp_latest_time_ms
);

   logic                  out_valid_ff, out_valid_in;
   logic                  pend_ff, pend_in;
   logic                  time_valid_ff, time_valid_in;
   logic [TIME_BITS-1:0]  earliest_ff, earliest_in;
   logic [TIME_BITS-1:0]  latest_ff, latest_in;
   logic [32:0]           pend_value_ff, pend_value_in;
   signal_kind_type       kind_ff, kind_in;
   logic                  channel_ff, channel_in;
   logic [32:0]           value_ff, value_in;
   logic [55:0]           source_ff, source_in;
   logic [TIME_BITS-1:0]  stamp_ff, stamp_in;
   logic                  last_ff, last_in;
   logic                  out_free;
   logic                  take_second;
   logic                  take_new;

   always_comb begin
      out_free    = !out_valid_ff || rsp_pop;
      take_second = out_free && pend_ff;
      take_new    = out_free && !pend_ff && !q_stat.empty;
      q_pop       = take_new;

      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      time_valid_in = time_valid_ff;
      earliest_in   = earliest_ff;
      latest_in     = latest_ff;
      pend_value_in = pend_value_ff;
      kind_in       = kind_ff;
      channel_in    = channel_ff;
      value_in      = value_ff;
      source_in     = source_ff;
      stamp_in      = stamp_ff;
      last_in       = last_ff;

      priority if (take_second) begin
         // second sample keeps kind, source and timestamps of the one just shown
         out_valid_in = 1'b1;
         pend_in      = 1'b0;
         channel_in   = 1'b1;
         value_in     = pend_value_ff;
         last_in      = 1'b1;
      end else if (take_new) begin
         out_valid_in  = 1'b1;
         pend_in       = q_entry.two_samples;
         pend_value_in = q_entry.value1;
         kind_in       = q_entry.kind;
         channel_in    = 1'b0;
         value_in      = q_entry.value0;
         source_in     = q_entry.source;
         stamp_in      = q_entry.time_ms;
         last_in       = !q_entry.two_samples;
         time_valid_in = 1'b1;
         if (!time_valid_ff) begin
            earliest_in = q_entry.time_ms;
            latest_in   = q_entry.time_ms;
         end else begin
            if (q_entry.time_ms < earliest_ff) earliest_in = q_entry.time_ms;
            if (q_entry.time_ms > latest_ff)   latest_in   = q_entry.time_ms;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         time_valid_ff <= 1'b0;
         earliest_ff   <= '0;
         latest_ff     <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_ff       <= pend_in;
         time_valid_ff <= time_valid_in;
         earliest_ff   <= earliest_in;
         latest_ff     <= latest_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      kind_ff       <= kind_in;
      channel_ff    <= channel_in;
      value_ff      <= value_in;
      source_ff     <= source_in;
      stamp_ff      <= stamp_in;
      last_ff       <= last_in;
   end

   assign rsp_empty            = !out_valid_ff;
   assign rsp_signal_kind      = kind_ff;
   assign rsp_channel          = channel_ff;
   assign rsp_sample_value     = value_ff;
   assign rsp_sample_source    = source_ff;
   assign rsp_sample_time_ms   = stamp_ff;
   assign rsp_last_of_frame    = last_ff;
   assign rsp_earliest_time_ms = earliest_ff;
   assign rsp_latest_time_ms   = latest_ff;

   `CFSD_ASSERT_IMP(a_pend_shown, pend_ff, out_valid_ff && !channel_ff && !last_ff)
   `CFSD_ASSERT_IMP(a_span_order, time_valid_ff, earliest_ff <= latest_ff)
   `CFSD_ASSERT_IMP(a_no_pop_pend, pend_ff, !q_pop)

endmodule
